/* sv/cnms_pkg.sv */
// ----------------------------------------------------------------------------
// cnms_pkg: shared types, constants and calendar helpers
// Holds the candidate time type, the configuration bundle, the register
// index codes and the month-length rule used by the search block.
// ----------------------------------------------------------------------------
package cnms_pkg;

  // Search window.
  localparam int SEARCH_DAYS    = 366;
  localparam int MIN_PER_DAY    = 1440;
  localparam int SEARCH_MINUTES = SEARCH_DAYS * MIN_PER_DAY;
  localparam int LEFT_W         = $clog2(SEARCH_MINUTES + 1);

  // Field widths.
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int WDAY_W   = 3;
  localparam int CFG_W    = 60;
  localparam int CFG_IDX_W = 3;

  // Leap-year cycle of the Gregorian calendar. The quotient of the year by
  // the cycle comes from a reciprocal multiplication, (year * 5243) >> 21,
  // which is exact over the whole 14-bit year range; the residue follows by
  // multiplying back and subtracting.
  localparam int LEAP_CYCLE = 400;
  localparam int R400_W     = 9;
  localparam int R400_RECIP = 5243;
  localparam int R400_SHIFT = 21;
  localparam int Q400_W     = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCHEDULE_VALID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTE_MASK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOUR_MASK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MONTHDAY_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MONTH_MASK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY_MASK   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_EITHER     = 3'd6;

  typedef logic [LEFT_W-1:0] left_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [R400_W-1:0]   r400;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [WDAY_W-1:0]   weekday;
  } cand_t;

  typedef struct packed {
    logic [59:0] minute_mask;
    logic [23:0] hour_mask;
    logic [30:0] monthday_mask;
    logic [11:0] month_mask;
    logic [6:0]  weekday_mask;
    logic        day_either;
  } cfg_t;

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_SEARCH  = 1'b1
  } step_op_t;

  typedef struct packed {
    logic stop;
    logic hit;
  } step_res_t;

  // Leap year from the year's residue modulo 400.
  function automatic logic is_leap(input logic [R400_W-1:0] r);
    logic century;
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r[1:0] == 2'd0) && !century;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

/* sv/cnms_step.sv */
// ----------------------------------------------------------------------------
// cnms_step: one step of the calendar search
// Either advances the candidate by one minute, or makes one search decision:
// skip the rest of the day, skip the rest of the hour, report a hit, or move
// on by one minute, charging the skipped minutes to the remaining budget and stopping once it runs out.
// ----------------------------------------------------------------------------
module cnms_step (
  input  cnms_pkg::step_op_t  op,
  input  cnms_pkg::cfg_t      cfg,
  input  cnms_pkg::cand_t     cand,
  input  cnms_pkg::left_t     left,
  output cnms_pkg::cand_t     cand_next,
  output cnms_pkg::left_t     left_next,
  output cnms_pkg::step_res_t res
);

  function automatic cnms_pkg::cand_t adv_day(input cnms_pkg::cand_t c);
    cnms_pkg::cand_t n;
    n = c;
    n.weekday = (c.weekday == 3'd6) ? 3'd0 : c.weekday + 3'd1;
    if (c.day >= cnms_pkg::month_len(c.month, cnms_pkg::is_leap(c.r400))) begin
      n.day = 5'd1;
      if (c.month >= 4'd12) begin
        n.month = 4'd1;
        n.year  = c.year + 14'd1;
        if (c.year == '1) begin
          n.r400 = '0;
        end else if (c.r400 == 9'(cnms_pkg::LEAP_CYCLE - 1)) begin
          n.r400 = '0;
        end else begin
          n.r400 = c.r400 + 9'd1;
        end
      end else begin
        n.month = c.month + 4'd1;
      end
    end else begin
      n.day = c.day + 5'd1;
    end
    return n;
  endfunction

  function automatic cnms_pkg::cand_t adv_hour(input cnms_pkg::cand_t c);
    cnms_pkg::cand_t n;
    n = c;
    n.minute = '0;
    if (c.hour >= 5'd23) begin
      n.hour = '0;
      n = adv_day(n);
    end else begin
      n.hour = c.hour + 5'd1;
    end
    return n;
  endfunction

  function automatic cnms_pkg::cand_t adv_minute(input cnms_pkg::cand_t c);
    cnms_pkg::cand_t n;
    n = c;
    if (c.minute >= 6'd59) begin
      n = adv_hour(c);
    end else begin
      n.minute = c.minute + 6'd1;
    end
    return n;
  endfunction

  logic            month_ok;
  logic            mday_ok;
  logic            wday_ok;
  logic            day_ok;
  logic            hour_ok;
  logic            minute_ok;
  logic [10:0]     skip_day;
  logic [10:0]     skip_hour;
  cnms_pkg::cand_t day_start;

  assign month_ok  = cfg.month_mask[cand.month - 4'd1];
  assign mday_ok   = cfg.monthday_mask[cand.day - 5'd1];
  assign wday_ok   = cfg.weekday_mask[cand.weekday];
  assign day_ok    = month_ok && (cfg.day_either ? (mday_ok || wday_ok) : (mday_ok && wday_ok));
  assign hour_ok   = cfg.hour_mask[cand.hour];
  assign minute_ok = cfg.minute_mask[cand.minute];

  // Minutes from the candidate to the next midnight and to the next hour.
  assign skip_hour = 11'(7'd60 - 7'(cand.minute));
  assign skip_day  = 11'(11'(5'd23 - cand.hour) * 11'd60) + skip_hour;

  always_comb begin
    day_start        = cand;
    day_start.hour   = '0;
    day_start.minute = '0;
  end

  always_comb begin
    cand_next = cand;
    left_next = left;
    res.stop  = 1'b0;
    res.hit   = 1'b0;
    if (op == cnms_pkg::OP_ADVANCE) begin
      cand_next = adv_minute(cand);
    end else if (left == '0) begin
      res.stop = 1'b1;
    end else if (!day_ok) begin
      if (cnms_pkg::left_t'(skip_day) >= left) begin
        res.stop = 1'b1;
      end else begin
        left_next = left - cnms_pkg::left_t'(skip_day);
        cand_next = adv_day(day_start);
      end
    end else if (!hour_ok) begin
      if (cnms_pkg::left_t'(skip_hour) >= left) begin
        res.stop = 1'b1;
      end else begin
        left_next = left - cnms_pkg::left_t'(skip_hour);
        cand_next = adv_hour(cand);
      end
    end else if (minute_ok) begin
      res.stop = 1'b1;
      res.hit  = 1'b1;
    end else begin
      left_next = left - cnms_pkg::left_t'(1);
      cand_next = adv_minute(cand);
    end
  end

endmodule

/* sv/cron_next_match_search_top.sv */
// ----------------------------------------------------------------------------
// cron_next_match_search_top: next matching minute of a cron schedule
// One request at a time; the search loop through cnms_step makes one
// decision a cycle over up to 366 days of minutes, and a result held by
// the receiver stalls the next one. Synchronous reset clears the schedule
// registers and the sequencer; no sweep.
// ----------------------------------------------------------------------------
module cron_next_match_search_top (
  input  logic        clk,
  input  logic        rst,

  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data,

  // Request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] start_year,
  input  logic [3:0]  start_month,
  input  logic [4:0]  start_day,
  input  logic [4:0]  start_hour,
  input  logic [5:0]  start_minute,
  input  logic [5:0]  start_second,
  input  logic [2:0]  start_weekday,

  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [13:0] next_year,
  output logic [3:0]  next_month,
  output logic [4:0]  next_day,
  output logic [4:0]  next_hour,
  output logic [5:0]  next_minute,
  output logic [2:0]  next_weekday
);

  // Phases of a request; a disabled schedule goes from S_IDLE to S_RESULT:
  //   S_IDLE   waits for a request and clamps the fields that need no calendar.
  //   S_MOD    finds the year modulo 400: a reciprocal multiplication
  //            gives the registered quotient, then multiplying back and
  //            subtracting leaves the residue, so that leap years follow.
  //   S_CLAMP  limits the day of month to the length of the start month.
  //   S_START  moves to the next whole minute and loads the minute budget.
  //   S_SEARCH makes one decision a cycle in the shared step unit.
  //   S_RESULT hands the answer to the output register once it is free.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MOD    = 6'b000010,
    S_CLAMP  = 6'b000100,
    S_START  = 6'b001000,
    S_SEARCH = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t                   state;
  logic                     schedule_valid;
  cnms_pkg::cfg_t           cfg;
  cnms_pkg::cand_t          cand;
  cnms_pkg::left_t          left;
  logic [13:0]              rem;
  logic                     mod_step;
  logic [cnms_pkg::Q400_W-1:0] quot;
  logic                     res_found;

  cnms_pkg::step_op_t       op;
  cnms_pkg::cand_t          cand_next;
  cnms_pkg::left_t          left_next;
  cnms_pkg::step_res_t      res;

  logic [cnms_pkg::Q400_W-1:0] quot_est;
  logic [13:0]              quot_x400;
  logic [13:0]              rem_next;
  logic [4:0]               dim;
  logic                     in_fire;
  logic                     out_free;

  // The configuration port never stalls; the sender must make writes only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // The seconds of the start time never matter: the search always begins at
  // the following whole minute.
  logic unused_second;
  assign unused_second = ^start_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      schedule_valid <= 1'b0;
      cfg            <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cnms_pkg::REG_SCHEDULE_VALID: schedule_valid        <= cfg_data[0];
        cnms_pkg::REG_MINUTE_MASK:    cfg.minute_mask       <= cfg_data[59:0];
        cnms_pkg::REG_HOUR_MASK:      cfg.hour_mask         <= cfg_data[23:0];
        cnms_pkg::REG_MONTHDAY_MASK:  cfg.monthday_mask     <= cfg_data[30:0];
        cnms_pkg::REG_MONTH_MASK:     cfg.month_mask        <= cfg_data[11:0];
        cnms_pkg::REG_WEEKDAY_MASK:   cfg.weekday_mask      <= cfg_data[6:0];
        cnms_pkg::REG_DAY_EITHER:     cfg.day_either        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Year modulo 400. The quotient from the reciprocal product is registered
  // first; then it is multiplied back by 400 and subtracted.
  // The residue is below 400, so its low nine bits hold all of it.
  assign quot_est  = cnms_pkg::Q400_W'((27'(rem) * 27'(cnms_pkg::R400_RECIP))
                                      >> cnms_pkg::R400_SHIFT);
  assign quot_x400 = 14'(quot) * 14'(cnms_pkg::LEAP_CYCLE);
  assign rem_next  = rem - quot_x400;

  assign dim = cnms_pkg::month_len(cand.month, cnms_pkg::is_leap(cand.r400));

  // The step unit is used once to advance to the next minute, and then once
  // a cycle for the search decisions.
  assign op = (state == S_START) ? cnms_pkg::OP_ADVANCE : cnms_pkg::OP_SEARCH;

  cnms_step u_step (
    .op        (op),
    .cfg       (cfg),
    .cand      (cand),
    .left      (left),
    .cand_next (cand_next),
    .left_next (left_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In S_RESULT a departing result is replaced by the new one at once.
      if (out_valid && out_ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= schedule_valid ? S_MOD : S_RESULT;
          end
        end
        S_MOD: begin
          if (mod_step == 1'b0) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (res.stop) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; they need no reset.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          // Out-of-range fields are saturated; weekday seven wraps to Sunday.
          cand.year    <= start_year;
          cand.month   <= (start_month == 4'd0) ? 4'd1 :
                          (start_month > 4'd12) ? 4'd12 : start_month;
          cand.day     <= (start_day == 5'd0) ? 5'd1 : start_day;
          cand.hour    <= (start_hour > 5'd23) ? 5'd23 : start_hour;
          cand.minute  <= (start_minute > 6'd59) ? 6'd59 : start_minute;
          cand.weekday <= (start_weekday == 3'd7) ? 3'd0 : start_weekday;
          rem          <= start_year;
          mod_step     <= 1'b1;
          res_found    <= 1'b0;
        end
      end
      S_MOD: begin
        if (mod_step) begin
          quot     <= quot_est;
          mod_step <= 1'b0;
        end else begin
          cand.r400 <= rem_next[8:0];
        end
      end
      S_CLAMP: begin
        if (cand.day > dim) begin
          cand.day <= dim;
        end
      end
      S_START: begin
        cand <= cand_next;
        left <= cnms_pkg::left_t'(cnms_pkg::SEARCH_MINUTES);
      end
      S_SEARCH: begin
        if (res.stop) begin
          res_found <= res.hit;
        end else begin
          cand <= cand_next;
          left <= left_next;
        end
      end
      S_RESULT: begin
        // A miss, or a disabled schedule, reports all fields as zero.
        if (out_free) begin
          found        <= res_found;
          next_year    <= res_found ? cand.year    : '0;
          next_month   <= res_found ? cand.month   : '0;
          next_day     <= res_found ? cand.day     : '0;
          next_hour    <= res_found ? cand.hour    : '0;
          next_minute  <= res_found ? cand.minute  : '0;
          next_weekday <= res_found ? cand.weekday : '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cron next-match search block
// Loads a run of cron schedules through the register channel. Each start
// time request is checked against the table's answer or a behavioural calendar walk kept in the
// bench. A short table of hand-picked requests comes first, then constrained
// random requests under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;

  // One full search window, in candidate minutes.
  localparam int unsigned WINDOW_MINUTES = 366 * 1440;
  // Random requests whose match lies further out than this are redrawn, so
  // that the run stays short even if the block walks one minute per cycle.
  localparam int unsigned WALK_LIMIT = 20000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  weekday;
  } res_t;

  // Raw register words of one schedule; bits above a field's width are kept
  // as written, so that the block's masking is exercised as well.
  typedef struct packed {
    logic [59:0] valid;
    logic [59:0] minute;
    logic [59:0] hour;
    logic [59:0] mday;
    logic [59:0] month;
    logic [59:0] wday;
    logic [59:0] either;
  } sched_t;

  // One row of the directed table. A schedule number of -1 keeps the
  // schedule that is loaded; a negative found value leaves the result to
  // the calendar walk.
  typedef struct packed {
    int   sel;
    int   want_found;
    req_t rq;
    res_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [59:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [13:0] start_year = '0;
  logic [3:0]  start_month = '0;
  logic [4:0]  start_day = '0;
  logic [4:0]  start_hour = '0;
  logic [5:0]  start_minute = '0;
  logic [5:0]  start_second = '0;
  logic [2:0]  start_weekday = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [13:0] next_year;
  logic [3:0]  next_month;
  logic [4:0]  next_day;
  logic [4:0]  next_hour;
  logic [5:0]  next_minute;
  logic [2:0]  next_weekday;

  // The bench's own copy of the schedule registers, updated as each write
  // is accepted. All registers come out of reset as zero.
  logic [59:0] cfg_word [7];

  // Expected results, oldest first, one per accepted request.
  res_t pending_matches [$];
  row_t dir_rows [$];
  sched_t dir_sched [8];

  int send_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int matches_seen = 0;
  int schedules_loaded = 0;
  res_t mon_got;
  res_t mon_want;

  cron_next_match_search_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .start_hour   (start_hour),
    .start_minute (start_minute),
    .start_second (start_second),
    .start_weekday(start_weekday),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .next_year    (next_year),
    .next_month   (next_month),
    .next_day     (next_day),
    .next_hour    (next_hour),
    .next_minute  (next_minute),
    .next_weekday (next_weekday)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar walk
  // ---------------------------------------------------------------------------

  // Gregorian month length; year 0 and every multiple of 400 are leap years.
  function automatic int unsigned days_in_month(int unsigned y, int unsigned mo);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (mo)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Step to the next calendar day; the year wraps within its 14 bits.
  function automatic void step_day(inout int unsigned y, mo, d, wd);
    wd = (wd + 1) % 7;
    d++;
    if (d > days_in_month(y, mo)) begin
      d = 1;
      mo++;
      if (mo > 12) begin
        mo = 1;
        y = (y + 1) % 16384;
      end
    end
  endfunction

  // Step to minute zero of the next hour, rolling into the next day.
  function automatic void step_hour(inout int unsigned y, mo, d, h, mi, wd);
    mi = 0;
    h++;
    if (h >= 24) begin
      h = 0;
      step_day(y, mo, d, wd);
    end
  endfunction

  // Works out the first matching minute after a start time under the
  // schedule currently held in cfg_word. Out-of-range start fields are
  // clamped first. Whole days and whole hours that cannot match are passed
  // over in one go, but still use up their minutes of the search window.
  // The number of window minutes used is handed back, so that the caller
  // can keep the run short.
  function automatic void predict_match(input req_t rq, output res_t r,
                                        output int unsigned used);
    int unsigned y, mo, d, h, mi, wd, left, skip;
    bit hit, md, wk, day_ok;
    y = rq.year;
    mo = rq.month;
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    d = rq.day;
    if (d < 1) d = 1;
    if (d > days_in_month(y, mo)) d = days_in_month(y, mo);
    h = (rq.hour > 23) ? 23 : rq.hour;
    mi = (rq.minute > 59) ? 59 : rq.minute;
    wd = rq.weekday % 7;
    r = '0;
    used = 0;
    hit = 1'b0;
    if (!cfg_word[cnms_pkg::REG_SCHEDULE_VALID][0]) return;
    // The seconds are dropped: the first candidate is the next whole minute.
    mi++;
    if (mi >= 60) step_hour(y, mo, d, h, mi, wd);
    left = WINDOW_MINUTES;
    while (left > 0 && !hit) begin
      md = cfg_word[cnms_pkg::REG_MONTHDAY_MASK][d - 1];
      wk = cfg_word[cnms_pkg::REG_WEEKDAY_MASK][wd];
      day_ok = cfg_word[cnms_pkg::REG_MONTH_MASK][mo - 1] &&
               (cfg_word[cnms_pkg::REG_DAY_EITHER][0] ? (md || wk) : (md && wk));
      if (!day_ok) begin
        skip = (23 - h) * 60 + (60 - mi);
        if (skip >= left) begin
          left = 0;
        end else begin
          left -= skip;
          h = 0;
          mi = 0;
          step_day(y, mo, d, wd);
        end
      end else if (!cfg_word[cnms_pkg::REG_HOUR_MASK][h]) begin
        skip = 60 - mi;
        if (skip >= left) begin
          left = 0;
        end else begin
          left -= skip;
          step_hour(y, mo, d, h, mi, wd);
        end
      end else if (cfg_word[cnms_pkg::REG_MINUTE_MASK][mi]) begin
        hit = 1'b1;
      end else begin
        left--;
        mi++;
        if (mi >= 60) step_hour(y, mo, d, h, mi, wd);
      end
    end
    used = WINDOW_MINUTES - left;
    if (hit) begin
      r.found = 1'b1;
      r.year = 14'(y);
      r.month = 4'(mo);
      r.day = 5'(d);
      r.hour = 5'(h);
      r.minute = 6'(mi);
      r.weekday = 3'(wd);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sched_t make_schedule(logic [59:0] valid, minute, hour, mday,
                                           logic [59:0] month, wday, either);
    sched_t s;
    s.valid = valid;
    s.minute = minute;
    s.hour = hour;
    s.mday = mday;
    s.month = month;
    s.wday = wday;
    s.either = either;
    return s;
  endfunction

  function automatic void add_row(int sel, int y, int mo, int d, int h, int mi,
                                  int s, int wd, int ef, int ey, int emo,
                                  int ed, int eh, int emi, int ewd);
    row_t rw;
    rw.sel = sel;
    rw.want_found = ef;
    rw.rq.year = 14'(y);
    rw.rq.month = 4'(mo);
    rw.rq.day = 5'(d);
    rw.rq.hour = 5'(h);
    rw.rq.minute = 6'(mi);
    rw.rq.second = 6'(s);
    rw.rq.weekday = 3'(wd);
    rw.want.found = (ef > 0);
    rw.want.year = 14'(ey);
    rw.want.month = 4'(emo);
    rw.want.day = 5'(ed);
    rw.want.hour = 5'(eh);
    rw.want.minute = 6'(emi);
    rw.want.weekday = 3'(ewd);
    dir_rows = {dir_rows, rw};
  endfunction

  // Idle cycles before the next request: each cycle is idle with the given
  // chance in a hundred.
  function automatic int idle_gap(int pct);
    int n;
    n = 0;
    while (n < 200 && $urandom_range(99) < pct) n++;
    return n;
  endfunction

  // Waits until every outstanding result has come back, then writes all
  // seven registers in index order while the block is idle.
  task automatic load_schedule(input sched_t s);
    logic [59:0] words [7];
    words[cnms_pkg::REG_SCHEDULE_VALID] = s.valid;
    words[cnms_pkg::REG_MINUTE_MASK] = s.minute;
    words[cnms_pkg::REG_HOUR_MASK] = s.hour;
    words[cnms_pkg::REG_MONTHDAY_MASK] = s.mday;
    words[cnms_pkg::REG_MONTH_MASK] = s.month;
    words[cnms_pkg::REG_WEEKDAY_MASK] = s.wday;
    words[cnms_pkg::REG_DAY_EITHER] = s.either;
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= words[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_word[i] = words[i];
    end
    cfg_valid <= 1'b0;
    schedules_loaded++;
  endtask

  // Presents one request after an optional idle gap and holds it until the
  // block takes it. Valid is left high so that a back-to-back request does
  // not drop it for a cycle.
  task automatic send_request(input req_t rq, input res_t want, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_year <= rq.year;
    start_month <= rq.month;
    start_day <= rq.day;
    start_hour <= rq.hour;
    start_minute <= rq.minute;
    start_second <= rq.second;
    start_weekday <= rq.weekday;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_matches = {pending_matches, want};
    requests_sent++;
  endtask

  task automatic note_failure(input string what, input res_t want, input res_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected %0d %0d-%0d-%0d %0d:%0d wd %0d,",
               $realtime, what, want.found, want.year, want.month, want.day,
               want.hour, want.minute, want.weekday);
      $display("    got %0d %0d-%0d-%0d %0d:%0d wd %0d",
               got.found, got.year, got.month, got.day, got.hour, got.minute,
               got.weekday);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and checking
  // ---------------------------------------------------------------------------

  // Both the handshake and the current ready are sampled as they stood
  // before this edge; the new ready is applied after it.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        mon_got = {found, next_year, next_month, next_day, next_hour, next_minute,
                   next_weekday};
        results_seen++;
        if (mon_got.found) matches_seen++;
        if (pending_matches.size() == 0) begin
          note_failure("result with no request outstanding", '0, mon_got);
        end else begin
          mon_want = pending_matches.pop_front();
          if (mon_got.found !== mon_want.found || mon_got.year !== mon_want.year ||
              mon_got.month !== mon_want.month || mon_got.day !== mon_want.day ||
              mon_got.hour !== mon_want.hour || mon_got.minute !== mon_want.minute ||
              mon_got.weekday !== mon_want.weekday) begin
            note_failure("result mismatch", mon_want, mon_got);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    row_t rw;
    req_t rq;
    res_t want;
    int unsigned used;
    bit usable;
    bit noisy;
    logic [59:0] vw, mw, hw, dw, mow, wkw, ew;

    for (int i = 0; i < 7; i++) cfg_word[i] = '0;

    // Directed schedules. Number one sets every bit of every word, so the
    // search always stops at the very next minute and the table can state
    // the answer outright. Number two is the same with the enable bit clear
    // but the spare bits set; number three is enabled with nothing allowed,
    // which walks the whole window. Four sets only the top bit of each mask,
    // with no weekday bit; five only the bottom bit. Six and seven exercise the
    // either-day and both-day rules with weekday and day of month restricted.
    dir_sched[0] = '0;
    dir_sched[1] = make_schedule('1, '1, '1, '1, '1, '1, '1);
    dir_sched[2] = make_schedule(60'hFFF_FFFF_FFFF_FFFE, '1, '1, '1, '1, '1, '1);
    dir_sched[3] = make_schedule(60'd1, '0, '0, '0, '0, '0, '0);
    dir_sched[4] = make_schedule(60'd1, 60'd1 << 59, 60'd1 << 23, 60'd1 << 30,
                                 60'd1 << 11, 60'd0, 60'd1);
    dir_sched[5] = make_schedule(60'd1, 60'd1, 60'd1, 60'd1, 60'd1, 60'd1, 60'd0);
    dir_sched[6] = make_schedule(60'd1, 60'd1 << 30, 60'd1 << 9, 60'd1 << 14,
                                 60'hFFF, 60'b10, 60'd1);
    dir_sched[7] = make_schedule(60'd1, 60'd1, 60'd1, 60'd1 << 12, 60'hFFF,
                                 60'd1 << 5, 60'd0);

    // Straight after reset nothing is enabled, so the answer is not found.
    add_row(-1, 2023, 5, 5, 10, 10, 0, 5, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 2024, 3, 10, 12, 30, 45, 0, 1, 2024, 3, 10, 12, 31, 0);
    add_row(-1, 9998, 12, 31, 23, 59, 59, 5, 1, 9999, 1, 1, 0, 0, 6);
    // The year wraps from the top of its range to zero.
    add_row(-1, 16383, 12, 31, 23, 59, 0, 3, 1, 0, 1, 1, 0, 0, 4);
    // Leap days: ordinary leap year, century, fourth century and year zero.
    add_row(-1, 2024, 2, 28, 23, 59, 0, 3, 1, 2024, 2, 29, 0, 0, 4);
    add_row(-1, 1900, 2, 28, 23, 59, 0, 3, 1, 1900, 3, 1, 0, 0, 4);
    add_row(-1, 2000, 2, 28, 23, 59, 0, 1, 1, 2000, 2, 29, 0, 0, 2);
    add_row(-1, 0, 2, 28, 23, 59, 0, 0, 1, 0, 2, 29, 0, 0, 1);
    // Out-of-range start fields are clamped; weekday seven counts as Sunday.
    add_row(-1, 2023, 0, 5, 10, 0, 63, 2, 1, 2023, 1, 5, 10, 1, 2);
    add_row(-1, 2023, 15, 31, 23, 59, 0, 0, 1, 2024, 1, 1, 0, 0, 1);
    add_row(-1, 2023, 6, 0, 0, 0, 0, 4, 1, 2023, 6, 1, 0, 1, 4);
    add_row(-1, 2023, 4, 31, 23, 59, 0, 0, 1, 2023, 5, 1, 0, 0, 1);
    add_row(-1, 2023, 7, 15, 31, 63, 0, 6, 1, 2023, 7, 16, 0, 0, 0);
    add_row(-1, 2023, 1, 1, 0, 0, 0, 7, 1, 2023, 1, 1, 0, 1, 0);
    add_row(-1, 2023, 2, 31, 10, 20, 0, 1, 1, 2023, 2, 28, 10, 21, 1);
    add_row(-1, 1, 1, 1, 0, 0, 0, 1, 1, 1, 1, 1, 0, 1, 1);
    // Disabled schedule, then an enabled one that can never match.
    add_row(2, 2023, 5, 5, 10, 10, 0, 5, 0, 0, 0, 0, 0, 0, 0);
    add_row(3, 2023, 5, 5, 10, 10, 0, 5, 0, 0, 0, 0, 0, 0, 0);
    add_row(4, 2023, 12, 31, 23, 58, 0, 0, 1, 2023, 12, 31, 23, 59, 0);
    add_row(5, 2022, 12, 31, 23, 59, 0, 6, 1, 2023, 1, 1, 0, 0, 0);
    add_row(6, 2023, 7, 10, 8, 0, 0, 1, -1, 0, 0, 0, 0, 0, 0);
    add_row(-1, 2023, 7, 11, 10, 0, 0, 2, -1, 0, 0, 0, 0, 0, 0);
    add_row(7, 2023, 1, 1, 0, 0, 0, 0, -1, 0, 0, 0, 0, 0, 0);

    // Reset is held from the start, released once and never asserted again.
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table, with light idling on both sides.
    send_pct = 6;
    stall_pct = 6;
    for (int i = 0; i < dir_rows.size(); i++) begin
      rw = dir_rows[i];
      if (rw.sel >= 0) load_schedule(dir_sched[rw.sel]);
      predict_match(rw.rq, want, used);
      if (rw.want_found >= 0) want = rw.want;
      send_request(rw.rq, want, idle_gap(send_pct));
    end

    // Random part: four idling patterns, two schedules each. The first
    // schedule of a pattern has dense masks everywhere; the second keeps the
    // day masks dense but thins out the hour and minute masks, so that the
    // hour skipping gets a work-out. Spare register bits are random.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_pct = 0;  stall_pct = 0;  end
        1:       begin send_pct = 73; stall_pct = 0;  end
        2:       begin send_pct = 0;  stall_pct = 73; end
        default: begin send_pct = 6;  stall_pct = 6;  end
      endcase
      for (int c = 0; c < 2; c++) begin
        vw = 60'({$urandom, $urandom});
        vw[0] = 1'b1;
        if (c == 0) begin
          mw = 60'({$urandom, $urandom}) | 60'({$urandom, $urandom});
          hw = 60'({$urandom, $urandom}) | 60'({$urandom, $urandom});
        end else begin
          mw = (60'({$urandom, $urandom}) & 60'({$urandom, $urandom}) &
                60'({$urandom, $urandom})) | (60'd1 << $urandom_range(59));
          hw = (60'({$urandom, $urandom}) & 60'({$urandom, $urandom})) |
               (60'd1 << $urandom_range(23));
        end
        dw = 60'({$urandom, $urandom}) | 60'({$urandom, $urandom});
        mow = 60'({$urandom, $urandom}) | 60'({$urandom, $urandom});
        wkw = 60'({$urandom, $urandom}) | 60'({$urandom, $urandom});
        ew = 60'({$urandom, $urandom});
        load_schedule(make_schedule(vw, mw, hw, dw, mow, wkw, ew));

        for (int k = 0; k < 10; k++) begin
          // Draw start times until one has its match close enough; mostly
          // valid dates, about one in seven with fields out of range.
          usable = 1'b0;
          for (int t = 0; t < 200 && !usable; t++) begin
            noisy = ($urandom_range(99) < 15);
            if (noisy) begin
              rq.year = 14'($urandom_range(16383));
              rq.month = 4'($urandom_range(15));
              rq.day = 5'($urandom_range(31));
              rq.hour = 5'($urandom_range(31));
              rq.minute = 6'($urandom_range(63));
              rq.weekday = 3'($urandom_range(7));
            end else begin
              rq.year = 14'($urandom_range(9998, 1));
              rq.month = 4'($urandom_range(12, 1));
              rq.day = 5'($urandom_range(days_in_month(rq.year, rq.month), 1));
              rq.hour = 5'($urandom_range(23));
              rq.minute = 6'($urandom_range(59));
              rq.weekday = 3'($urandom_range(6));
            end
            // Now and then start on the last evening before the year wraps.
            if ($urandom_range(24) == 0) begin
              rq.year = 14'h3FFF;
              rq.month = 4'd12;
              rq.day = 5'd31;
              rq.hour = 5'd23;
            end
            rq.second = 6'($urandom_range(63));
            predict_match(rq, want, used);
            usable = want.found && (used <= WALK_LIMIT);
          end
          if (usable) send_request(rq, want, idle_gap(send_pct));
        end
      end
    end

    // Drain, then give the block a while to show any stray result.
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("summary: %0d requests under %0d schedules, %0d results checked, %0d matched",
             requests_sent, schedules_loaded, results_seen, matches_seen);
    $display("summary: %0d failures; clamped fields, leap days, year wrap, both day rules",
             fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the longest legitimate run of this sequence, which
  // includes one full-window search that finds nothing.
  initial begin
    #400_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
sv/cnms_pkg.sv
sv/cnms_step.sv
sv/cron_next_match_search_top.sv
verif/tb.sv
